// ===== src/msivt_pkg.sv =====
// Shared types, constants and helpers for the MSI vector table.
`default_nettype none

package msivt_pkg;

    // Table geometry
    localparam int ENTRIES_DEF = 32;

    // Configuration port geometry: four 64-bit registers at 8-byte spacing
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 64;
    localparam int REG_SHIFT = 3;

    // Register reset values
    localparam logic [15:0] POOL_BASE_RST  = 16'h1000;
    localparam logic [15:0] POOL_LIMIT_RST = 16'h1FFF;

    // Function codes of a change request
    localparam logic [7:0] FN_MSI     = 8'd1;
    localparam logic [7:0] FN_MSI_ALT = 8'd3;
    localparam logic [7:0] FN_MSIX    = 8'd4;

    typedef enum logic [1:0] {
        ACT_CHANGE = 2'd0,
        ACT_QUERY  = 2'd1,
        ACT_WRITE  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_HW_ERR    = 2'd1,
        ST_PARAM_ERR = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ITYPE_NONE = 2'd0,
        ITYPE_MSI  = 2'd1,
        ITYPE_MSIX = 2'd2
    } itype_t;

    typedef enum logic [1:0] {
        REG_BUS_UNIT_ID = 2'd0,
        REG_WINDOW_BASE = 2'd1,
        REG_POOL_BASE   = 2'd2,
        REG_POOL_LIMIT  = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_RESOLVE,
        S_WREAD,
        S_FINISH
    } state_t;

    // Kind of result beat to build
    typedef enum logic [2:0] {
        RK_PARAM,
        RK_HW,
        RK_EMPTY,
        RK_GRANT,
        RK_SOURCE,
        RK_PULSE
    } res_kind_t;

    typedef struct packed {
        logic [31:0] device;
        logic [7:0]  count;
        logic [15:0] irq_base;
    } entry_t;

    typedef struct packed {
        logic [63:0] bus_unit_id;
        logic [63:0] window_base;
        logic [15:0] pool_base;
        logic [15:0] pool_limit;
        logic        pool_reload;
        logic [15:0] reload_value;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic      latch;
        logic      scan_start;
        logic      scan_step;
        logic      scan_stop;
        logic      wr_read;
        logic      alloc;
        logic      res_load;
        res_kind_t res_kind;
        logic      out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        action_t action;
        logic    fn_ok;
        logic    bus_ok;
        logic    present;
        logic    cnt_zero;
        logic    win_ok;
        logic    scan_hit;
        logic    scan_end;
        logic    found;
        logic    slot_ok;
        logic    count_match;
        logic    fits;
        logic    out_busy;
    } sts_t;

    // Map a function code to its interrupt kind
    function automatic itype_t irq_type_of(input logic [7:0] fn);
        itype_t t;
        case (fn) inside
            FN_MSI, FN_MSI_ALT: t = ITYPE_MSI;
            FN_MSIX:            t = ITYPE_MSIX;
            default:            t = ITYPE_NONE;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== src/msivt_regs.sv =====
// Configuration register file with its APB-style access port.
`default_nettype none

module msivt_regs
    import msivt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    logic [63:0] bus_unit_id_reg;
    logic [63:0] window_base_reg;
    logic [15:0] pool_base_reg;
    logic [15:0] pool_limit_reg;
    logic        wr_en;
    reg_idx_t    reg_idx;

    // Decode the access
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:REG_SHIFT]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Write registers on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_unit_id_reg <= '0;
            window_base_reg <= '0;
            pool_base_reg   <= POOL_BASE_RST;
            pool_limit_reg  <= POOL_LIMIT_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_BUS_UNIT_ID: bus_unit_id_reg <= pwdata;
                REG_WINDOW_BASE: window_base_reg <= pwdata;
                REG_POOL_BASE:   pool_base_reg   <= pwdata[15:0];
                REG_POOL_LIMIT:  pool_limit_reg  <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (reg_idx)
            REG_BUS_UNIT_ID: prdata = bus_unit_id_reg;
            REG_WINDOW_BASE: prdata = window_base_reg;
            REG_POOL_BASE:   prdata = {48'd0, pool_base_reg};
            REG_POOL_LIMIT:  prdata = {48'd0, pool_limit_reg};
            default:         prdata = '0;
        endcase
    end

    // Hand the settings on; a pool base write also reloads the bump pointer
    always_comb
    begin
        cfg.bus_unit_id  = bus_unit_id_reg;
        cfg.window_base  = window_base_reg;
        cfg.pool_base    = pool_base_reg;
        cfg.pool_limit   = pool_limit_reg;
        cfg.pool_reload  = wr_en && (reg_idx == REG_POOL_BASE);
        cfg.reload_value = pwdata[15:0];
    end

endmodule

`default_nettype wire

// ===== src/msivt_ctrl.sv =====
// Request sequencer: dispatch, table scan, resolution and result hand-off.
`default_nettype none

module msivt_ctrl
    import msivt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    input  sts_t      sts,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                unique case (sts.action)
                    ACT_CHANGE:
                    begin
                        if (!sts.fn_ok || !sts.bus_ok || !sts.present)
                        begin
                            cmd.res_load = 1'b1;
                            cmd.res_kind = RK_PARAM;
                            state_next   = S_FINISH;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    ACT_QUERY:
                    begin
                        if (!sts.bus_ok)
                        begin
                            cmd.res_load = 1'b1;
                            cmd.res_kind = RK_PARAM;
                            state_next   = S_FINISH;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    ACT_WRITE:
                    begin
                        if (!sts.win_ok)
                        begin
                            cmd.res_load = 1'b1;
                            cmd.res_kind = RK_EMPTY;
                            state_next   = S_FINISH;
                        end
                        else
                        begin
                            cmd.wr_read = 1'b1;
                            state_next  = S_WREAD;
                        end
                    end
                    default:
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_kind = RK_PARAM;
                        state_next   = S_FINISH;
                    end
                endcase
            end

            // Stop on a match, else on the first free entry or the table end
            S_SCAN:
            begin
                if (sts.scan_hit || sts.scan_end)
                begin
                    cmd.scan_stop = 1'b1;
                    state_next    = S_RESOLVE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end

            S_RESOLVE:
            begin
                cmd.res_load = 1'b1;
                state_next   = S_FINISH;
                if (sts.action == ACT_QUERY)
                begin
                    cmd.res_kind = sts.found ? RK_SOURCE : RK_HW;
                end
                else if (sts.cnt_zero)
                begin
                    cmd.res_kind = sts.found ? RK_EMPTY : RK_HW;
                end
                else if (sts.found)
                begin
                    cmd.res_kind = sts.count_match ? RK_GRANT : RK_HW;
                end
                else if (!sts.slot_ok || !sts.fits)
                begin
                    cmd.res_kind = RK_HW;
                end
                else
                begin
                    cmd.alloc    = 1'b1;
                    cmd.res_kind = RK_GRANT;
                end
            end

            S_WREAD:
            begin
                cmd.res_load = 1'b1;
                cmd.res_kind = RK_PULSE;
                state_next   = S_FINISH;
            end

            // Hold the result until the output register is free
            S_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/msivt_dp.sv =====
// Datapath: request latch, entry memory, scan counter, allocator and result registers.
`default_nettype none

module msivt_dp
    import msivt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  cmd_t             cmd,
    output sts_t             sts,
    input  cfg_t             cfg,
    input  wire logic [1:0]  action,
    input  wire logic [63:0] bus_id,
    input  wire logic        device_present,
    input  wire logic [31:0] device_addr,
    input  wire logic [7:0]  function_code,
    input  wire logic [7:0]  vector_count,
    input  wire logic [31:0] sequence_number,
    input  wire logic [15:0] vector_index,
    input  wire logic [20:0] window_offset,
    input  wire logic [15:0] message_data,
    input  wire logic        out_stall,
    output logic             out_valid,
    output logic      [1:0]  status,
    output logic      [7:0]  granted_count,
    output logic      [31:0] next_sequence,
    output logic      [1:0]  interrupt_type,
    output logic      [63:0] message_base,
    output logic      [15:0] source_number,
    output logic             edge_trigger,
    output logic             pulse_valid,
    output logic      [15:0] pulse_irq
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] END_IDX = CW'(ENTRIES);
    localparam logic [8:0]    WIN_LIM = 9'(ENTRIES);

    // Latched request
    logic [1:0]  action_reg;
    logic [63:0] bus_id_reg;
    logic        present_reg;
    logic [31:0] dev_reg;
    logic [7:0]  fn_reg;
    logic [7:0]  cnt_reg;
    logic [31:0] seq_reg;
    logic [15:0] vidx_reg;
    logic [20:0] off_reg;
    logic [15:0] mdata_reg;

    // Table
    entry_t              entry_mem [ENTRIES];
    logic [ENTRIES-1:0]  valid_reg;
    entry_t              rd_entry_reg;
    logic                rd_valid_reg;
    logic [IW-1:0]       rd_idx_reg;
    logic                rd_en;
    logic [IW-1:0]       rd_addr;

    // Scan and allocation
    logic [CW-1:0] idx_reg;
    logic          pend_reg;
    logic          found_reg;
    logic          slot_ok_reg;
    logic [15:0]   next_free_reg;
    logic [15:0]   start_reg;
    logic [16:0]   block_end;
    logic [8:0]    win_wide;
    logic [IW-1:0] win_addr;
    logic [IW-1:0] slot_addr;
    logic [IW-1:0] sel_idx;
    logic          idx_at_end;
    logic          slot_free;
    logic [15:0]   pulse_base;
    logic [15:0]   pulse_vec;

    // Result staging
    status_t     res_status_reg;
    logic [7:0]  res_granted_reg;
    logic [31:0] res_next_seq_reg;
    itype_t      res_itype_reg;
    logic [63:0] res_base_reg;
    logic [15:0] res_source_reg;
    logic        res_edge_reg;
    logic        res_pulse_valid_reg;
    logic [15:0] res_pulse_irq_reg;

    // Output register
    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    logic [7:0]  out_granted_reg;
    logic [31:0] out_next_seq_reg;
    logic [1:0]  out_itype_reg;
    logic [63:0] out_base_reg;
    logic [15:0] out_source_reg;
    logic        out_edge_reg;
    logic        out_pulse_valid_reg;
    logic [15:0] out_pulse_irq_reg;

    // Capture the input beat
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            action_reg  <= action;
            bus_id_reg  <= bus_id;
            present_reg <= device_present;
            dev_reg     <= device_addr;
            fn_reg      <= function_code;
            cnt_reg     <= vector_count;
            seq_reg     <= sequence_number;
            vidx_reg    <= vector_index;
            off_reg     <= window_offset;
            mdata_reg   <= message_data;
        end
    end

    // Address decode
    assign win_wide   = {4'd0, off_reg[20:16]};
    assign win_addr   = win_wide[IW-1:0];
    assign slot_addr  = idx_reg[IW-1:0];
    assign idx_at_end = (idx_reg == END_IDX);
    assign slot_free  = idx_at_end ? 1'b1 : !valid_reg[slot_addr];
    assign rd_en      = cmd.scan_step || cmd.wr_read;
    assign rd_addr    = cmd.scan_step ? slot_addr : win_addr;
    assign sel_idx    = found_reg ? rd_idx_reg : slot_addr;
    assign block_end  = {1'b0, start_reg} + {9'd0, cnt_reg};
    assign pulse_base = rd_valid_reg ? rd_entry_reg.irq_base : 16'd0;
    assign pulse_vec  = {2'b00, off_reg[15:2]} | mdata_reg;

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_entry_reg <= entry_mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
            rd_idx_reg   <= rd_addr;
        end
        if (cmd.alloc)
        begin
            entry_mem[slot_addr] <= '{device: dev_reg, count: cnt_reg, irq_base: start_reg};
        end
    end

    // Block start is the larger of the bump pointer and the pool base
    always_ff @(posedge clk)
    begin
        start_reg <= (next_free_reg > cfg.pool_base) ? next_free_reg : cfg.pool_base;
    end

    // Valid bits, scan counter and bump pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            slot_ok_reg   <= 1'b0;
            next_free_reg <= POOL_BASE_RST;
        end
        else
        begin
            if (cmd.scan_start)
            begin
                idx_reg  <= '0;
                pend_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                idx_reg  <= idx_reg + CW'(1);
                pend_reg <= 1'b1;
            end
            if (cmd.scan_stop)
            begin
                found_reg   <= sts.scan_hit;
                slot_ok_reg <= !idx_at_end;
            end
            if (cmd.alloc)
            begin
                valid_reg[slot_addr] <= 1'b1;
            end
            if (cfg.pool_reload)
            begin
                next_free_reg <= cfg.reload_value;
            end
            else if (cmd.alloc)
            begin
                next_free_reg <= block_end[15:0];
            end
        end
    end

    // Status to the controller
    always_comb
    begin
        sts.action      = action_t'(action_reg);
        sts.fn_ok       = (irq_type_of(fn_reg) != ITYPE_NONE);
        sts.bus_ok      = (bus_id_reg == cfg.bus_unit_id);
        sts.present     = present_reg;
        sts.cnt_zero    = (cnt_reg == 8'd0);
        sts.win_ok      = (win_wide < WIN_LIM);
        sts.scan_hit    = pend_reg && (rd_entry_reg.device == dev_reg);
        sts.scan_end    = slot_free;
        sts.found       = found_reg;
        sts.slot_ok     = slot_ok_reg;
        sts.count_match = (rd_entry_reg.count == cnt_reg);
        sts.fits        = (block_end <= ({1'b0, cfg.pool_limit} + 17'd1));
        sts.out_busy    = out_valid_reg && out_stall;
    end

    // Build the result beat
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            res_status_reg      <= ST_OK;
            res_granted_reg     <= '0;
            res_next_seq_reg    <= '0;
            res_itype_reg       <= ITYPE_NONE;
            res_base_reg        <= '0;
            res_source_reg      <= '0;
            res_edge_reg        <= 1'b0;
            res_pulse_valid_reg <= 1'b0;
            res_pulse_irq_reg   <= '0;
            case (cmd.res_kind)
                RK_PARAM: res_status_reg <= ST_PARAM_ERR;
                RK_HW:    res_status_reg <= ST_HW_ERR;
                RK_EMPTY: ;
                RK_GRANT:
                begin
                    res_granted_reg  <= cnt_reg;
                    res_next_seq_reg <= seq_reg + 32'd1;
                    res_itype_reg    <= irq_type_of(fn_reg);
                    res_base_reg     <= cfg.window_base | (64'(sel_idx) << 16);
                end
                RK_SOURCE:
                begin
                    res_source_reg <= rd_entry_reg.irq_base + vidx_reg;
                    res_edge_reg   <= 1'b1;
                end
                RK_PULSE:
                begin
                    res_pulse_valid_reg <= 1'b1;
                    res_pulse_irq_reg   <= pulse_base + pulse_vec;
                end
                default: ;
            endcase
        end
    end

    // Output register: load when free, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg      <= res_status_reg;
            out_granted_reg     <= res_granted_reg;
            out_next_seq_reg    <= res_next_seq_reg;
            out_itype_reg       <= res_itype_reg;
            out_base_reg        <= res_base_reg;
            out_source_reg      <= res_source_reg;
            out_edge_reg        <= res_edge_reg;
            out_pulse_valid_reg <= res_pulse_valid_reg;
            out_pulse_irq_reg   <= res_pulse_irq_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign granted_count  = out_granted_reg;
    assign next_sequence  = out_next_seq_reg;
    assign interrupt_type = out_itype_reg;
    assign message_base   = out_base_reg;
    assign source_number  = out_source_reg;
    assign edge_trigger   = out_edge_reg;
    assign pulse_valid    = out_pulse_valid_reg;
    assign pulse_irq      = out_pulse_irq_reg;

endmodule

`default_nettype wire

// ===== src/msi_vector_table.sv =====
// Top level of the MSI vector table: register port, sequencer and datapath.
`default_nettype none

// The block keeps a table of ENTRIES message-signalled-interrupt entries, each
// holding a device address, a vector count and a base interrupt number, and
// serves one request at a time: change (grant or check vectors for a device),
// query (translate a device vector to an interrupt number) and message write
// (decode entry and vector from the window offset and pulse the interrupt).
// Change and query requests walk the table one entry per cycle through the
// single read port of the entry memory, stopping at a match, at the first
// free entry or at the end of the table. A new request is taken as soon as
// the sequencer is back in idle, even while the previous result still waits
// in the output register. The table is empty straight after reset
// (per-entry valid bits), entries are never freed, and a write to the pool
// base register also reloads the interrupt allocator. Registers sit at byte
// address 8*i: bus unit id, window base, pool base, pool limit.

module msi_vector_table
    import msivt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // request channel
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        action,
    input  wire logic [63:0]       bus_id,
    input  wire logic              device_present,
    input  wire logic [31:0]       device_addr,
    input  wire logic [7:0]        function_code,
    input  wire logic [7:0]        vector_count,
    input  wire logic [31:0]       sequence_number,
    input  wire logic [15:0]       vector_index,
    input  wire logic [20:0]       window_offset,
    input  wire logic [15:0]       message_data,
    // result channel
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [1:0]        status,
    output logic      [7:0]        granted_count,
    output logic      [31:0]       next_sequence,
    output logic      [1:0]        interrupt_type,
    output logic      [63:0]       message_base,
    output logic      [15:0]       source_number,
    output logic                   edge_trigger,
    output logic                   pulse_valid,
    output logic      [15:0]       pulse_irq,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    // Configuration registers
    msivt_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer
    msivt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath
    msivt_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg             (cfg),
        .action          (action),
        .bus_id          (bus_id),
        .device_present  (device_present),
        .device_addr     (device_addr),
        .function_code   (function_code),
        .vector_count    (vector_count),
        .sequence_number (sequence_number),
        .vector_index    (vector_index),
        .window_offset   (window_offset),
        .message_data    (message_data),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .status          (status),
        .granted_count   (granted_count),
        .next_sequence   (next_sequence),
        .interrupt_type  (interrupt_type),
        .message_base    (message_base),
        .source_number   (source_number),
        .edge_trigger    (edge_trigger),
        .pulse_valid     (pulse_valid),
        .pulse_irq       (pulse_irq)
    );

    // One request in flight: an accepted beat closes the request channel
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted while another is in flight");

    // A pulse only comes with a successful message write
    a_pulse_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pulse_valid) |-> (status == ST_OK && !edge_trigger
            && granted_count == 8'd0))
        else $error("pulse beat carries other result fields");

    // A translated source is a successful query and nothing else
    a_source_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && edge_trigger) |-> (status == ST_OK && !pulse_valid
            && interrupt_type == ITYPE_NONE))
        else $error("query beat carries other result fields");

    // A grant always names its interrupt kind
    a_grant_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && granted_count != 8'd0) |-> (status == ST_OK
            && (interrupt_type == ITYPE_MSI || interrupt_type == ITYPE_MSIX)))
        else $error("grant without interrupt kind");

endmodule

`default_nettype wire

// ===== dv/tb_msi_vector_table.sv =====
// Testbench for msi_vector_table: directed and random requests scored against a table predictor.
module tb_msi_vector_table
    import msivt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH    = ENTRIES_DEF;
    localparam int PHASE_ITEMS    = 600;
    localparam int DEV_POOL_SIZE  = 48;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT = 4000;

    // Action code outside the defined set
    localparam logic [1:0] ACT_UNDEFINED = 2'd3;

    // Function codes that a change request must reject
    localparam logic [7:0] FN_ZERO     = 8'h00;
    localparam logic [7:0] FN_RESERVED = 8'h02;
    localparam logic [7:0] FN_TOP      = 8'hFF;

    // Fixed device keys for the directed part
    localparam logic [31:0] DEV_A = 32'hFFFF_FFFF;
    localparam logic [31:0] DEV_B = 32'h0000_0000;
    localparam logic [31:0] DEV_C = 32'h1234_5678;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] bus_id;
        logic        present;
        logic [31:0] dev;
        logic [7:0]  fn;
        logic [7:0]  count;
        logic [31:0] seq;
        logic [15:0] vec_idx;
        logic [20:0] offset;
        logic [15:0] data;
    } irq_request_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  granted;
        logic [31:0] next_seq;
        itype_t      itype;
        logic [63:0] msg_base;
        logic [15:0] source;
        logic        edge_trig;
        logic        pulse;
        logic [15:0] pulse_irq;
    } irq_reply_t;

    // Predicts the reply to each accepted request and checks the replies in order
    class irq_grant_tracker;
        logic [63:0] unit_id;
        logic [63:0] window_base;
        logic [15:0] pool_base;
        logic [15:0] pool_limit;
        logic [15:0] next_free;
        logic [31:0] dev_key [TABLE_DEPTH];
        logic [7:0]  vectors [TABLE_DEPTH];
        logic [15:0] dev_irq_base [TABLE_DEPTH];
        irq_reply_t  awaited [$];
        int          mismatches;
        int          requests_seen;
        int          replies_seen;
        int          grants_made;
        int          hw_errors;
        int          param_errors;
        int          translations;
        int          pulses;

        function new();
            unit_id     = '0;
            window_base = '0;
            pool_base   = POOL_BASE_RST;
            pool_limit  = POOL_LIMIT_RST;
            next_free   = POOL_BASE_RST;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                dev_key[i]      = '0;
                vectors[i]      = '0;
                dev_irq_base[i] = '0;
            end
            mismatches    = 0;
            requests_seen = 0;
            replies_seen  = 0;
            grants_made   = 0;
            hw_errors     = 0;
            param_errors  = 0;
            translations  = 0;
            pulses        = 0;
        endfunction

        function void load_register(reg_idx_t idx, logic [63:0] val);
            case (idx)
                REG_BUS_UNIT_ID: unit_id = val;
                REG_WINDOW_BASE: window_base = val;
                REG_POOL_BASE:
                begin
                    pool_base = val[15:0];
                    next_free = val[15:0];
                end
                default: pool_limit = val[15:0];
            endcase
        endfunction

        // Scan from slot 0, stop at a match or at the first free slot
        function int find_slot(logic [31:0] dev, bit allocate);
            int i;
            for (i = 0; i < TABLE_DEPTH; i++)
            begin
                if (vectors[i] == 8'd0)
                    break;
                if (dev_key[i] == dev)
                    return i;
            end
            if (i < TABLE_DEPTH && allocate)
                return i;
            return -1;
        endfunction

        function logic [7:0] count_of(logic [31:0] dev);
            int slot;
            slot = find_slot(dev, 1'b0);
            return (slot < 0) ? 8'd0 : vectors[slot];
        endfunction

        function int slots_in_use();
            int used;
            used = 0;
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (vectors[i] != 8'd0)
                    used++;
            return used;
        endfunction

        function irq_reply_t predict(irq_request_t rq);
            irq_reply_t  y;
            itype_t      kind;
            int          slot;
            logic [15:0] start;
            logic [16:0] last;
            logic [15:0] vec;
            y = '0;
            y.status = ST_OK;
            case (rq.action)
                ACT_CHANGE:
                begin
                    if (rq.fn == FN_MSI || rq.fn == FN_MSI_ALT)
                        kind = ITYPE_MSI;
                    else if (rq.fn == FN_MSIX)
                        kind = ITYPE_MSIX;
                    else
                    begin
                        y.status = ST_PARAM_ERR;
                        return y;
                    end
                    if (rq.bus_id != unit_id || !rq.present)
                    begin
                        y.status = ST_PARAM_ERR;
                        return y;
                    end
                    // Zero count only checks that the device has an entry
                    if (rq.count == 8'd0)
                    begin
                        if (find_slot(rq.dev, 1'b0) < 0)
                            y.status = ST_HW_ERR;
                        return y;
                    end
                    slot = find_slot(rq.dev, 1'b1);
                    if (slot < 0 || (vectors[slot] != 8'd0 && vectors[slot] != rq.count))
                    begin
                        y.status = ST_HW_ERR;
                        return y;
                    end
                    // Fresh slot: bump the allocator, refuse if the block overruns the pool
                    if (vectors[slot] == 8'd0)
                    begin
                        start = (next_free > pool_base) ? next_free : pool_base;
                        last  = {1'b0, start} + 17'(rq.count) - 17'd1;
                        if (last > {1'b0, pool_limit})
                        begin
                            y.status = ST_HW_ERR;
                            return y;
                        end
                        dev_irq_base[slot] = start;
                        vectors[slot]      = rq.count;
                        dev_key[slot]      = rq.dev;
                        next_free          = 16'(last + 17'd1);
                        grants_made++;
                    end
                    y.granted  = rq.count;
                    y.next_seq = rq.seq + 32'd1;
                    y.itype    = kind;
                    y.msg_base = window_base | (64'(slot) << 16);
                end
                ACT_QUERY:
                begin
                    if (rq.bus_id != unit_id)
                    begin
                        y.status = ST_PARAM_ERR;
                        return y;
                    end
                    slot = find_slot(rq.dev, 1'b0);
                    if (slot < 0)
                    begin
                        y.status = ST_HW_ERR;
                        return y;
                    end
                    y.source    = dev_irq_base[slot] + rq.vec_idx;
                    y.edge_trig = 1'b1;
                end
                ACT_WRITE:
                begin
                    // Entry from the upper offset bits, vector from the word index ORed with the message data
                    if (int'(rq.offset[20:16]) < TABLE_DEPTH)
                    begin
                        vec         = {2'b00, rq.offset[15:2]} | rq.data;
                        y.pulse     = 1'b1;
                        y.pulse_irq = dev_irq_base[rq.offset[20:16]] + vec;
                    end
                end
                default: y.status = ST_PARAM_ERR;
            endcase
            return y;
        endfunction

        function void take_request(irq_request_t rq);
            irq_reply_t y;
            y = predict(rq);
            awaited.push_back(y);
            requests_seen++;
            if (y.status == ST_HW_ERR)
                hw_errors++;
            if (y.status == ST_PARAM_ERR)
                param_errors++;
            if (y.edge_trig)
                translations++;
            if (y.pulse)
                pulses++;
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        task report_mismatch(string what);
            $display("[tb] reply %0d: %s", replies_seen, what);
            mismatches++;
        endtask

        task check_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %h, want %h", name, got, want));
        endtask

        task match_reply(irq_reply_t got);
            irq_reply_t want;
            replies_seen++;
            if (awaited.size() == 0)
            begin
                report_mismatch("reply with no request pending");
                return;
            end
            want = awaited.pop_front();
            check_field("status", got.status, want.status);
            check_field("granted_count", got.granted, want.granted);
            check_field("next_sequence", got.next_seq, want.next_seq);
            check_field("interrupt_type", got.itype, want.itype);
            check_field("message_base", got.msg_base, want.msg_base);
            check_field("source_number", got.source, want.source);
            check_field("edge_trigger", got.edge_trig, want.edge_trig);
            check_field("pulse_valid", got.pulse, want.pulse);
            check_field("pulse_irq", got.pulse_irq, want.pulse_irq);
        endtask
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        action;
    logic [63:0]       bus_id;
    logic              device_present;
    logic [31:0]       device_addr;
    logic [7:0]        function_code;
    logic [7:0]        vector_count;
    logic [31:0]       sequence_number;
    logic [15:0]       vector_index;
    logic [20:0]       window_offset;
    logic [15:0]       message_data;
    logic              out_valid;
    logic              out_stall;
    logic [1:0]        status;
    logic [7:0]        granted_count;
    logic [31:0]       next_sequence;
    logic [1:0]        interrupt_type;
    logic [63:0]       message_base;
    logic [15:0]       source_number;
    logic              edge_trigger;
    logic              pulse_valid;
    logic [15:0]       pulse_irq;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    irq_grant_tracker tracker;
    logic [31:0]      dev_pool [DEV_POOL_SIZE];
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    bit               hold_go = 1'b0;

    msi_vector_table uut (.*);

    always #4 clk = ~clk;

    // Every field random; the builders below overwrite what they care about
    function automatic irq_request_t scrambled_request();
        irq_request_t rq;
        rq.action  = 2'($urandom_range(0, 3));
        rq.bus_id  = {$urandom, $urandom};
        rq.present = 1'($urandom);
        rq.dev     = $urandom;
        rq.fn      = 8'($urandom);
        rq.count   = 8'($urandom);
        rq.seq     = $urandom;
        rq.vec_idx = 16'($urandom);
        rq.offset  = 21'($urandom);
        rq.data    = 16'($urandom);
        return rq;
    endfunction

    function automatic irq_request_t change_req(logic [31:0] dev, logic [7:0] fn,
                                                logic [7:0] count);
        irq_request_t rq;
        rq         = scrambled_request();
        rq.action  = ACT_CHANGE;
        rq.bus_id  = tracker.unit_id;
        rq.present = 1'b1;
        rq.dev     = dev;
        rq.fn      = fn;
        rq.count   = count;
        return rq;
    endfunction

    function automatic irq_request_t query_req(logic [31:0] dev, logic [15:0] idx);
        irq_request_t rq;
        rq         = scrambled_request();
        rq.action  = ACT_QUERY;
        rq.bus_id  = tracker.unit_id;
        rq.dev     = dev;
        rq.vec_idx = idx;
        return rq;
    endfunction

    function automatic irq_request_t write_req(logic [20:0] offset, logic [15:0] data);
        irq_request_t rq;
        rq        = scrambled_request();
        rq.action = ACT_WRITE;
        rq.offset = offset;
        rq.data   = data;
        return rq;
    endfunction

    // Mostly well-formed requests on a small device set, a little pure noise
    function automatic irq_request_t random_request();
        irq_request_t rq;
        int unsigned  pick;
        int unsigned  sub;
        logic [7:0]   held;
        rq   = scrambled_request();
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return rq;
        rq.dev = dev_pool[$urandom_range(0, DEV_POOL_SIZE - 1)];
        case ($urandom_range(0, 19))
            0: ;
            1: rq.bus_id = tracker.unit_id ^ (64'd1 << $urandom_range(0, 63));
            default: rq.bus_id = tracker.unit_id;
        endcase
        if (pick < 45)
        begin
            rq.action  = ACT_CHANGE;
            rq.present = ($urandom_range(0, 19) != 0);
            case ($urandom_range(0, 9))
                0: ;
                1, 2, 3: rq.fn = FN_MSI;
                4, 5, 6: rq.fn = FN_MSI_ALT;
                default: rq.fn = FN_MSIX;
            endcase
            held = tracker.count_of(rq.dev);
            sub  = $urandom_range(0, 99);
            if (sub < 10)
                rq.count = 8'd0;
            else if (sub < 55 && held != 8'd0)
                rq.count = held;
            else if (sub < 90)
                rq.count = 8'($urandom_range(1, 8));
        end
        else if (pick < 75)
            rq.action = ACT_QUERY;
        else
        begin
            rq.action = ACT_WRITE;
            if ($urandom_range(0, 1) == 0)
                rq.data = '0;
        end
        return rq;
    endfunction

    // Offer one request from a falling edge; return at the falling edge after acceptance
    task automatic send_request(input irq_request_t rq);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        action          = rq.action;
        bus_id          = rq.bus_id;
        device_present  = rq.present;
        device_addr     = rq.dev;
        function_code   = rq.fn;
        vector_count    = rq.count;
        sequence_number = rq.seq;
        vector_index    = rq.vec_idx;
        window_offset   = rq.offset;
        message_data    = rq.data;
        in_valid        = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.take_request(rq);
        @(negedge clk);
    endtask

    // Register write: setup beat then access beat
    task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'(idx) << REG_SHIFT;
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        tracker.load_register(idx, val);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic drain_replies();
        while (tracker.outstanding() != 0)
            @(negedge clk);
    endtask

    // Result side: random stall, plus one long hold-off on request
    initial
    begin
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go && !hold_taken)
            begin
                hold_left  = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else
                out_stall = (recv_idle_pct != 0) && ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Score every accepted reply beat
    always @(posedge clk)
    begin : reply_monitor
        irq_reply_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.status    = status_t'(status);
            got.granted   = granted_count;
            got.next_seq  = next_sequence;
            got.itype     = itype_t'(interrupt_type);
            got.msg_base  = message_base;
            got.source    = source_number;
            got.edge_trig = edge_trigger;
            got.pulse     = pulse_valid;
            got.pulse_irq = pulse_irq;
            tracker.match_reply(got);
        end
    end

    // Abort when no handshake happens for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("[tb] no handshake for %0d cycles, %0d replies outstanding",
                 quiet, tracker.outstanding());
        $display("[msi_vector_table] ERROR");
        $finish;
    end

    initial
    begin
        irq_request_t rq;
        tracker         = new();
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        action          = ACT_CHANGE;
        bus_id          = '0;
        device_present  = 1'b0;
        device_addr     = '0;
        function_code   = '0;
        vector_count    = '0;
        sequence_number = '0;
        vector_index    = '0;
        window_offset   = '0;
        message_data    = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;

        // Device keys for random traffic, extremes included
        for (int i = 0; i < DEV_POOL_SIZE; i++)
            dev_pool[i] = $urandom;
        dev_pool[0] = 32'h0000_0000;
        dev_pool[1] = 32'hFFFF_FFFF;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: pool at the top of the number space so the bump pointer wraps and blocks past the top are refused
        write_reg(REG_BUS_UNIT_ID, '1);
        write_reg(REG_WINDOW_BASE, '1);
        write_reg(REG_POOL_BASE, 64'h0000_0000_0000_FFF0);
        write_reg(REG_POOL_LIMIT, 64'h0000_0000_0000_FFFF);
        send_idle_pct = 32;
        recv_idle_pct = 64;

        send_request(query_req(DEV_A, 16'h0000));
        send_request(change_req(DEV_A, FN_MSI, 8'd0));
        rq     = change_req(DEV_A, FN_MSI, 8'd8);
        rq.seq = '1;
        send_request(rq);
        send_request(change_req(DEV_B, FN_MSIX, 8'd8));
        send_request(change_req(DEV_C, FN_MSI_ALT, 8'd255));
        send_request(change_req(DEV_C, FN_MSI_ALT, 8'd1));
        send_request(change_req(DEV_A, FN_MSI, 8'd9));
        send_request(change_req(DEV_A, FN_MSIX, 8'd8));
        send_request(change_req(DEV_A, FN_MSI, 8'd0));
        send_request(change_req(DEV_A, FN_ZERO, 8'd8));
        send_request(change_req(DEV_A, FN_RESERVED, 8'd8));
        send_request(change_req(DEV_A, FN_TOP, 8'd8));
        rq        = change_req(DEV_A, FN_MSI, 8'd8);
        rq.bus_id = '0;
        send_request(rq);
        rq         = change_req(DEV_A, FN_MSI, 8'd8);
        rq.present = 1'b0;
        send_request(rq);
        send_request(query_req(DEV_A, 16'hFFFF));
        send_request(query_req(DEV_B, 16'h0010));
        rq         = query_req(DEV_C, 16'h0005);
        rq.present = 1'b0;
        rq.fn      = FN_ZERO;
        send_request(rq);
        rq        = query_req(DEV_A, 16'h0000);
        rq.bus_id = 64'h7FFF_FFFF_FFFF_FFFF;
        send_request(rq);
        send_request(write_req(21'h00_FFFC, 16'h0000));
        send_request(write_req(21'h01_0000, 16'hFFFF));
        send_request(write_req(21'h1F_FFFF, 16'hAAAA));
        rq        = write_req(21'h00_0000, 16'h0000);
        rq.action = ACT_UNDEFINED;
        send_request(rq);
        in_valid = 1'b0;

        // Random phases, each under its own register settings and idle pattern
        for (int phase = 0; phase < 3; phase++)
        begin
            drain_replies();
            case (phase)
                0:
                begin
                    write_reg(REG_BUS_UNIT_ID, {$urandom, $urandom});
                    write_reg(REG_WINDOW_BASE, {$urandom, $urandom});
                    write_reg(REG_POOL_BASE, 64'h0000);
                    write_reg(REG_POOL_LIMIT, 64'h01FF);
                    send_idle_pct = 32;
                    recv_idle_pct = 64;
                end
                1:
                begin
                    write_reg(REG_BUS_UNIT_ID, '0);
                    write_reg(REG_WINDOW_BASE, '0);
                    write_reg(REG_POOL_BASE, 64'h3000);
                    write_reg(REG_POOL_LIMIT, 64'h0000);
                    send_idle_pct = 64;
                    recv_idle_pct = 32;
                end
                default:
                begin
                    write_reg(REG_BUS_UNIT_ID, '1);
                    write_reg(REG_WINDOW_BASE, {$urandom, $urandom});
                    write_reg(REG_POOL_BASE, 64'($urandom_range(16'h4000, 16'h8000)));
                    write_reg(REG_POOL_LIMIT, 64'hFFFF);
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // Hold the result side off long enough to back up the request side
                if (phase == 2 && i == 100)
                    hold_go = 1'b1;
                send_request(random_request());
            end
            in_valid = 1'b0;
        end

        drain_replies();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("[tb] %0d requests, %0d replies: %0d new grants, %0d hardware errors,",
                 tracker.requests_seen, tracker.replies_seen, tracker.grants_made,
                 tracker.hw_errors);
        $display("[tb] %0d parameter errors, %0d translations, %0d pulses,",
                 tracker.param_errors, tracker.translations, tracker.pulses);
        $display("[tb] %0d of %0d slots in use, %0d mismatches",
                 tracker.slots_in_use(), TABLE_DEPTH, tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("[msi_vector_table] OK");
        else
            $display("[msi_vector_table] ERROR");
        $finish;
    end
endmodule

// ===== files.f =====
src/msivt_pkg.sv
src/msivt_regs.sv
src/msivt_ctrl.sv
src/msivt_dp.sv
src/msi_vector_table.sv
dv/tb_msi_vector_table.sv
